>>> src/lcpd_pkg.sv
// lcpd_pkg: shared widths, reset values, codes and the sensor weight table
// for the line centroid pid drive block
// no dependencies
`default_nettype none

package lcpd_pkg;

    // sensor array
    localparam int NUM_SENS = 8;
    localparam int SIDX_W   = 3;
    localparam int WGT_W    = 7;
    localparam int SUM_W    = 9;    // up to 360
    localparam int CNT_W    = 4;    // up to 8
    localparam int DVS_W    = 3;    // divisor is a count of 1..7
    localparam int QUO_W    = 17;   // sum * 256 / count fits 17 bits
    localparam int FRAC_W   = 8;

    // register and datapath widths
    localparam int THRESH_W = 12;
    localparam int GAIN_W   = 16;
    localparam int SPEED_W  = 16;
    localparam int ERR_W    = 16;
    localparam int INTEG_W  = 32;
    localparam int OPB_W    = 17;   // signed operand of the shared multiplier
    localparam int PROD_W   = 34;
    localparam int ACC_W    = 50;
    localparam int PID_SH   = 9;
    localparam int PID_W    = ACC_W - PID_SH;
    localparam int SPD_X_W  = PID_W + 1;

    // apb port
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;

    // line center, 45.0 in q8.8
    localparam int CENTER_Q88 = 45 * 256;

    // register indexes
    localparam logic [2:0] REG_THRESH = 3'd0;
    localparam logic [2:0] REG_GAIN_P = 3'd1;
    localparam logic [2:0] REG_GAIN_D = 3'd2;
    localparam logic [2:0] REG_GAIN_I = 3'd3;
    localparam logic [2:0] REG_CRUISE = 3'd4;
    localparam logic [2:0] REG_LIMIT  = 3'd5;

    // register reset values
    localparam logic [THRESH_W-1:0] RST_THRESH = 12'd900;
    localparam logic [GAIN_W-1:0]   RST_GAIN_P = 16'd256;
    localparam logic [GAIN_W-1:0]   RST_GAIN_D = 16'd2560;
    localparam logic [GAIN_W-1:0]   RST_GAIN_I = 16'd0;
    localparam logic [SPEED_W-1:0]  RST_CRUISE = 16'd1792;
    localparam logic [SPEED_W-1:0]  RST_LIMIT  = 16'd5120;

    // marker codes
    localparam logic [1:0] MARK_TRACK = 2'd0;
    localparam logic [1:0] MARK_NONE  = 2'd1;
    localparam logic [1:0] MARK_ALL   = 2'd2;

    // configuration seen by the datapath
    typedef struct packed {
        logic [THRESH_W-1:0] thresh;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_d;
        logic [GAIN_W-1:0]   gain_i;
        logic [SPEED_W-1:0]  cruise;
        logic [SPEED_W-1:0]  limit;
    } t_cfg;

    // weight of each sensor, outermost right first
    function automatic logic [WGT_W-1:0] sensor_weight(input logic [SIDX_W-1:0] idx);
        logic [WGT_W-1:0] w;
        case (idx)
            3'd0:    w = 7'd10;
            3'd1:    w = 7'd20;
            3'd2:    w = 7'd30;
            3'd3:    w = 7'd40;
            3'd4:    w = 7'd50;
            3'd5:    w = 7'd60;
            3'd6:    w = 7'd70;
            default: w = 7'd80;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/lcpd_regs.sv
// lcpd_regs: apb register file for threshold, gains and speed settings
// depends on lcpd_pkg
`default_nettype none

module lcpd_regs
    import lcpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh <= RST_THRESH;
            r_cfg.gain_p <= RST_GAIN_P;
            r_cfg.gain_d <= RST_GAIN_D;
            r_cfg.gain_i <= RST_GAIN_I;
            r_cfg.cruise <= RST_CRUISE;
            r_cfg.limit  <= RST_LIMIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESH: r_cfg.thresh <= pwdata[THRESH_W-1:0];
                REG_GAIN_P: r_cfg.gain_p <= pwdata[GAIN_W-1:0];
                REG_GAIN_D: r_cfg.gain_d <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: r_cfg.gain_i <= pwdata[GAIN_W-1:0];
                REG_CRUISE: r_cfg.cruise <= pwdata[SPEED_W-1:0];
                REG_LIMIT:  r_cfg.limit  <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_THRESH: prdata = {{(APB_DW-THRESH_W){1'b0}}, r_cfg.thresh};
            REG_GAIN_P: prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.gain_p};
            REG_GAIN_D: prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.gain_d};
            REG_GAIN_I: prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.gain_i};
            REG_CRUISE: prdata = {{(APB_DW-SPEED_W){1'b0}}, r_cfg.cruise};
            REG_LIMIT:  prdata = {{(APB_DW-SPEED_W){1'b0}}, r_cfg.limit};
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/lcpd_div.sv
// lcpd_div: restoring divider, one quotient bit per cycle, small divisor
// depends on lcpd_pkg
`default_nettype none

module lcpd_div
    import lcpd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [QUO_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [QUO_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(QUO_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_quo;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              take;

    // one trial subtraction per cycle
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign take  = (trial >= {1'b0, r_dvs});

    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // dividend shifts out at the top, quotient bits shift in below
                r_rem <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], take};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> src/line_centroid_pid_drive.sv
// line_centroid_pid_drive: line position from eight sensors, pid steering of two wheel speeds
// a tracked line item runs through accept, 17 divider steps, divider done, error, the multiply
// phase (4 products and a drain), pid, speed and the result register; a marker item goes from
// accept straight to the result register. one item at a time: the next item is taken only after
// the result register is loaded, later while an earlier result waits on a stall
// synchronous active-low reset restores register defaults and clears pid state; lcpd_* parts
`default_nettype none

module line_centroid_pid_drive
    import lcpd_pkg::*;
#(
    parameter int SENSOR_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // sensor item channel
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SENSOR_BITS-1:0] i_sense_r3,
    input  wire logic [SENSOR_BITS-1:0] i_sense_r2,
    input  wire logic [SENSOR_BITS-1:0] i_sense_r1,
    input  wire logic [SENSOR_BITS-1:0] i_sense_r0,
    input  wire logic [SENSOR_BITS-1:0] i_sense_l0,
    input  wire logic [SENSOR_BITS-1:0] i_sense_l1,
    input  wire logic [SENSOR_BITS-1:0] i_sense_l2,
    input  wire logic [SENSOR_BITS-1:0] i_sense_l3,
    // result item channel
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic        [SPEED_W-1:0]   o_wheel_left,
    output logic        [SPEED_W-1:0]   o_wheel_right,
    output logic        [1:0]           o_marker,
    output logic signed [ERR_W-1:0]     o_line_error,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready
);

    localparam int CMP_W = (SENSOR_BITS > THRESH_W) ? SENSOR_BITS : THRESH_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_PID,
        ST_SPD,
        ST_DONE
    } t_state;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    // register file
    lcpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // dark sensor sum and count
    logic [SENSOR_BITS-1:0] sense [NUM_SENS];
    logic [SUM_W-1:0]       dark_sum;
    logic [CNT_W-1:0]       dark_cnt;
    logic                   is_marker;
    logic [1:0]             mark_code;

    assign sense[0] = i_sense_r3;
    assign sense[1] = i_sense_r2;
    assign sense[2] = i_sense_r1;
    assign sense[3] = i_sense_r0;
    assign sense[4] = i_sense_l0;
    assign sense[5] = i_sense_l1;
    assign sense[6] = i_sense_l2;
    assign sense[7] = i_sense_l3;

    always_comb begin
        dark_sum = '0;
        dark_cnt = '0;
        for (int k = 0; k < NUM_SENS; k++) begin
            if (CMP_W'(sense[k]) < CMP_W'(cfg.thresh)) begin
                dark_sum = dark_sum + SUM_W'(sensor_weight(SIDX_W'(k)));
                dark_cnt = dark_cnt + 1'b1;
            end
        end
    end

    assign is_marker = (dark_cnt == '0) || (dark_cnt == CNT_W'(NUM_SENS));
    assign mark_code = (dark_cnt == '0) ? MARK_NONE : MARK_ALL;

    logic in_acc;
    logic out_free;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // divider for the centroid
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quot;

    assign div_start = in_acc && !is_marker;

    lcpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({dark_sum, {FRAC_W{1'b0}}}),
        .i_divisor  (dark_cnt[DVS_W-1:0]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // pid state and working registers
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [INTEG_W-1:0] r_integ;
    logic        [SPEED_W-1:0] r_held_left;
    logic        [SPEED_W-1:0] r_held_right;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [INTEG_W-1:0] r_integ_new;
    logic        [2:0]         r_step;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_hi;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PID_W-1:0]   r_pid;
    logic        [1:0]         r_mark;

    // output register
    logic                      r_ovalid;
    logic        [SPEED_W-1:0] r_out_left;
    logic        [SPEED_W-1:0] r_out_right;
    logic        [1:0]         r_out_mark;
    logic signed [ERR_W-1:0]   r_out_err;

    assign out_free = !r_ovalid || !i_stall;

    // error from quotient, integral with saturation
    logic signed [QUO_W:0]     err_wide;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;

    assign err_wide  = $signed({1'b0, div_quot}) - (QUO_W + 1)'(CENTER_Q88);
    assign integ_sum = (INTEG_W + 1)'(r_integ) + (INTEG_W + 1)'(err_wide);

    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    // shared multiplier operand select
    logic        [GAIN_W-1:0] mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        case (r_step)
            3'd0: begin
                mul_a = cfg.gain_p;
                mul_b = OPB_W'(r_err);
            end
            3'd1: begin
                mul_a = cfg.gain_d;
                mul_b = OPB_W'(r_err) - OPB_W'(r_prev_err);
            end
            3'd2: begin
                // low half of the integral, unsigned
                mul_a = cfg.gain_i;
                mul_b = $signed({1'b0, r_integ_new[15:0]});
            end
            default: begin
                // high half of the integral, signed, weighted by 2^16
                mul_a = cfg.gain_i;
                mul_b = OPB_W'($signed(r_integ_new[INTEG_W-1:16]));
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // accumulate and pid scaling, truncation toward zero
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_bias;

    assign prod_ext = r_prod_hi ? (ACC_W'(r_prod) <<< 16) : ACC_W'(r_prod);
    assign acc_bias = r_acc + (r_acc[ACC_W-1] ? ACC_W'((1 << PID_SH) - 1) : '0);

    // wheel speeds with clamp
    logic signed [SPD_X_W-1:0] spd_r;
    logic signed [SPD_X_W-1:0] spd_l;
    logic        [SPEED_W-1:0] clamp_r;
    logic        [SPEED_W-1:0] clamp_l;

    function automatic logic [SPEED_W-1:0] clamp_speed(
        input logic signed [SPD_X_W-1:0] v,
        input logic        [SPEED_W-1:0] hi
    );
        logic [SPEED_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(SPD_X_W-SPEED_W){1'b0}}, hi})) begin
            res = hi;
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    assign spd_r   = $signed({{(SPD_X_W-SPEED_W){1'b0}}, cfg.cruise}) + SPD_X_W'(r_pid);
    assign spd_l   = $signed({{(SPD_X_W-SPEED_W){1'b0}}, cfg.cruise}) - SPD_X_W'(r_pid);
    assign clamp_r = clamp_speed(spd_r, cfg.limit);
    assign clamp_l = clamp_speed(spd_l, cfg.limit);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = is_marker ? ST_DONE : ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_ERR;
            ST_ERR:  n_state = ST_MUL;
            ST_MUL:  if (r_step == 3'd4) n_state = ST_PID;
            ST_PID:  n_state = ST_SPD;
            ST_SPD:  n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer, datapath and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovalid     <= 1'b0;
            r_step       <= '0;
            r_prev_err   <= '0;
            r_integ      <= '0;
            r_held_left  <= '0;
            r_held_right <= '0;
        end else begin
            r_state <= n_state;
            // result valid: set when a result is loaded, cleared when taken
            if ((r_state == ST_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_mark <= is_marker ? mark_code : MARK_TRACK;
                    r_step <= '0;
                    r_acc  <= '0;
                end
                ST_DIV: ;
                ST_ERR: begin
                    r_err       <= err_wide[ERR_W-1:0];
                    r_integ_new <= integ_sat;
                end
                ST_MUL: begin
                    r_step    <= r_step + 1'b1;
                    r_prod    <= mul_p;
                    r_prod_hi <= (r_step == 3'd3);
                    if (r_step != 3'd0) begin
                        r_acc <= r_acc + prod_ext;
                    end
                end
                ST_PID: begin
                    r_pid <= acc_bias[ACC_W-1:PID_SH];
                end
                ST_SPD: begin
                    r_prev_err   <= r_err;
                    r_integ      <= r_integ_new;
                    r_held_left  <= clamp_l;
                    r_held_right <= clamp_r;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_left  <= r_held_left;
                        r_out_right <= r_held_right;
                        r_out_mark  <= r_mark;
                        r_out_err   <= (r_mark == MARK_TRACK) ? r_err : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_wheel_left  = r_out_left;
    assign o_wheel_right = r_out_right;
    assign o_marker      = r_out_mark;
    assign o_line_error  = r_out_err;

`ifndef SYNTHESIS
    // a marker result carries no error
    a_marker_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_marker != MARK_TRACK)) |-> (o_line_error == '0))
        else $error("marker result with nonzero line error");

    // a tracked error stays within the sensor span
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_marker == MARK_TRACK)) |->
        ((o_line_error >= -16'sd8960) && (o_line_error <= 16'sd8960)))
        else $error("line error outside sensor span");

    // an accepted item holds off the next one
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("input not stalled after accepted item");

    // divider completes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide phase");

    // pid state only changes at the speed update
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) != ST_SPD && $past(i_rst_n)) |-> $stable(r_integ))
        else $error("integral changed outside speed update");
`endif

endmodule

`default_nettype wire
